/* rtl/centroid_track_table_assert.svh */
// ----------------------------------------------------------------------------
// centroid track table assertion macros
// shared property forms used by the track table checks
// ----------------------------------------------------------------------------
`ifndef CENTROID_TRACK_TABLE_ASSERT_SVH
`define CENTROID_TRACK_TABLE_ASSERT_SVH

// same-cycle implication
`define CTT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("track table check failed");

// next-cycle implication
`define CTT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("track table check failed");

`endif

/* rtl/ctt_pkg.sv */
// ----------------------------------------------------------------------------
// ctt_pkg
// constants shared by the centroid track table modules
// ----------------------------------------------------------------------------
package ctt_pkg;
    localparam int NUM_W   = 32;
    localparam int MISS_W  = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_LIMIT   = 8'd1;

    localparam logic [MISS_W-1:0] LOST_LIMIT_RST = 8'd50;
    localparam logic [MISS_W-1:0] MISS_SAT       = 8'hFF;

    localparam logic KIND_BOX   = 1'b0;
    localparam logic KIND_FRAME = 1'b1;
endpackage

/* rtl/ctt_if.sv */
// ----------------------------------------------------------------------------
// ctt channel interfaces
// detection input, result output and register write channels
// ----------------------------------------------------------------------------
interface ctt_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [11:0] box_x;
    logic [11:0] box_y;
    logic [11:0] box_w;
    logic [11:0] box_h;
    modport source (output valid, kind, box_x, box_y, box_w, box_h, input ready);
    modport sink   (input valid, kind, box_x, box_y, box_w, box_h, output ready);
endinterface

interface ctt_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [31:0] track_number;
    logic [4:0]  table_position;
    logic        is_new;
    logic        dropped;
    logic [5:0]  live_count;
    logic [5:0]  removed_count;
    modport source (output valid, result_kind, track_number, table_position, is_new,
                    dropped, live_count, removed_count, input ready);
    modport sink   (input valid, result_kind, track_number, table_position, is_new,
                    dropped, live_count, removed_count, output ready);
endinterface

interface ctt_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/ctt_mem.sv */
// ----------------------------------------------------------------------------
// ctt_mem
// single write port, single read port entry memory, registered read
// ----------------------------------------------------------------------------
module ctt_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 88,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

/* rtl/ctt_dist.sv */
// ----------------------------------------------------------------------------
// ctt_dist
// three stage centre distance check: difference, square, sum and compare
// ----------------------------------------------------------------------------
module ctt_dist
    import ctt_pkg::*;
#(
    parameter int CB = 12,
    parameter int AW = 5
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  logic [4*CB-1:0] i_entry_box,
    input  logic [4*CB-1:0] i_det_box,
    input  logic [AW-1:0]   i_idx,
    input  logic [NUM_W-1:0] i_num,
    input  logic [31:0]     i_md_sq,
    output logic            o_vld,
    output logic            o_hit,
    output logic [AW-1:0]   o_idx,
    output logic [NUM_W-1:0] o_num,
    output logic            o_busy
);
    localparam int CW   = CB + 1;
    localparam int SQW  = 2 * CW;
    localparam int SUMW = SQW + 1;
    localparam int CMPW = (SUMW > 32) ? SUMW : 32;

    logic [CW-1:0] ex, ey, dx_c, dy_c, a_cx, a_cy;
    logic [CW-1:0] r_dx, r_dy;
    logic [SQW-1:0] r_sx, r_sy;
    logic [SUMW-1:0] sum;
    logic r_v1, r_v2, r_v3, r_hit;
    logic [AW-1:0] r_i1, r_i2, r_i3;
    logic [NUM_W-1:0] r_n1, r_n2, r_n3;

    // box layout: x, y, w, h from the top
    always_comb begin
        ex   = CW'(i_entry_box[4*CB-1 -: CB]) + CW'(i_entry_box[2*CB-1 -: CB] >> 1);
        ey   = CW'(i_entry_box[3*CB-1 -: CB]) + CW'(i_entry_box[CB-1 -: CB] >> 1);
        a_cx = CW'(i_det_box[4*CB-1 -: CB]) + CW'(i_det_box[2*CB-1 -: CB] >> 1);
        a_cy = CW'(i_det_box[3*CB-1 -: CB]) + CW'(i_det_box[CB-1 -: CB] >> 1);
        dx_c = (ex > a_cx) ? ex - a_cx : a_cx - ex;
        dy_c = (ey > a_cy) ? ey - a_cy : a_cy - ey;
        sum  = SUMW'(r_sx) + SUMW'(r_sy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_dx  <= dx_c;
        r_dy  <= dy_c;
        r_i1  <= i_idx;
        r_n1  <= i_num;
        r_sx  <= SQW'(r_dx) * SQW'(r_dx);
        r_sy  <= SQW'(r_dy) * SQW'(r_dy);
        r_i2  <= r_i1;
        r_n2  <= r_n1;
        r_hit <= CMPW'(sum) <= CMPW'(i_md_sq);
        r_i3  <= r_i2;
        r_n3  <= r_n2;
    end

    assign o_vld  = r_v3;
    assign o_hit  = r_hit;
    assign o_idx  = r_i3;
    assign o_num  = r_n3;
    assign o_busy = r_v1 | r_v2 | r_v3;
endmodule

/* rtl/centroid_track_table.sv */
// ----------------------------------------------------------------------------
// centroid_track_table
// ordered table of tracked boxes matched by squared centre distance
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  i_in      in         kind, box_x, box_y, box_w, box_h
//  o_out     out        result_kind, track_number, table_position, is_new,
//                       dropped, live_count, removed_count
//  i_cfg     in         index (0 max_distance, 1 lost_limit), data
//
//  a detection does one entry memory read per cycle until a hit is found,
//  feeding a three stage distance pipeline, which then drains
//  a frame end does one read per entry and one compacting write per surviving entry
//  reset is synchronous; the table comes up empty and needs no clearing pass
//  a result waits in the output register while the next item is worked on;
//  the block stalls only when a second result is ready before the first left
module centroid_track_table
    import ctt_pkg::*;
#(
    parameter int MAX_TRACKS = 32,
    parameter int COORD_BITS = 12
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ctt_in_if.sink    i_in,
    ctt_out_if.source o_out,
    ctt_cfg_if.sink   i_cfg
);
    `include "centroid_track_table_assert.svh"

    localparam int IDXW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CNTW  = $clog2(MAX_TRACKS + 1);
    localparam int BOXW  = 4 * COORD_BITS;
    localparam int WORDW = BOXW + NUM_W + MISS_W;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FRAME, S_DONE} t_state;

    t_state r_state;
    logic [CNTW-1:0] r_live, r_rd_idx, r_keep, r_removed;
    logic [MAX_TRACKS-1:0] r_upd;
    logic [NUM_W-1:0] r_next;
    logic [31:0] r_md_sq;
    logic [MISS_W-1:0] r_lost;
    logic [BOXW-1:0] r_box;
    logic r_p0_vld;
    logic [IDXW-1:0] r_p0_idx;
    logic r_found;
    logic [IDXW-1:0] r_hit_idx;
    logic [NUM_W-1:0] r_hit_num;

    // pending result and output register
    logic r_res_kind, r_res_new, r_res_drop;
    logic [NUM_W-1:0] r_res_num;
    logic [IDXW-1:0] r_res_pos;
    logic [CNTW-1:0] r_res_live, r_res_rem;
    logic r_out_vld, r_out_kind, r_out_new, r_out_drop;
    logic [NUM_W-1:0] r_out_num;
    logic [IDXW-1:0] r_out_pos;
    logic [CNTW-1:0] r_out_live, r_out_rem;

    // memory ports
    logic mem_rd_en, mem_wr_en;
    logic [IDXW-1:0] mem_rd_addr, mem_wr_addr;
    logic [WORDW-1:0] mem_rd_data, mem_wr_data;

    // distance pipeline
    logic d_vld, d_hit, d_busy;
    logic [IDXW-1:0] d_idx;
    logic [NUM_W-1:0] d_num;

    // frame end evaluation of the entry just read
    logic [MISS_W-1:0] old_miss, new_miss, limit;
    logic gone, scan_end, frame_end, room, out_free;

    assign out_free = !r_out_vld || o_out.ready;
    assign room     = r_live < CNTW'(MAX_TRACKS);
    assign scan_end = (r_found || r_rd_idx == r_live) && !r_p0_vld && !d_busy;
    assign frame_end = (r_rd_idx == r_live) && !r_p0_vld;

    always_comb begin
        limit    = (r_lost == '0) ? MISS_W'(1) : r_lost;
        old_miss = mem_rd_data[MISS_W-1:0];
        new_miss = (!r_upd[r_p0_idx] && old_miss != MISS_SAT) ? old_miss + 1'b1 : old_miss;
        gone     = new_miss >= limit;
    end

    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_rd_idx[IDXW-1:0];
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_keep[IDXW-1:0];
        mem_wr_data = {mem_rd_data[WORDW-1:MISS_W], new_miss};
        case (r_state)
            S_SCAN: begin
                mem_rd_en = (r_rd_idx < r_live) && !r_found;
                if (scan_end) begin
                    if (r_found) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = r_hit_idx;
                        mem_wr_data = {r_box, r_hit_num, MISS_W'(0)};
                    end else if (room) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = r_live[IDXW-1:0];
                        mem_wr_data = {r_box, r_next + 1'b1, MISS_W'(0)};
                    end
                end
            end
            S_FRAME: begin
                mem_rd_en = r_rd_idx < r_live;
                mem_wr_en = r_p0_vld && !gone;
            end
            default: begin
                mem_rd_en = 1'b0;
            end
        endcase
    end

    ctt_mem #(.DEPTH(MAX_TRACKS), .WIDTH(WORDW), .AW(IDXW)) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    ctt_dist #(.CB(COORD_BITS), .AW(IDXW)) u_dist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (r_p0_vld && r_state == S_SCAN),
        .i_entry_box (mem_rd_data[WORDW-1 -: BOXW]),
        .i_det_box   (r_box),
        .i_idx       (r_p0_idx),
        .i_num       (mem_rd_data[MISS_W +: NUM_W]),
        .i_md_sq     (r_md_sq),
        .o_vld       (d_vld),
        .o_hit       (d_hit),
        .o_idx       (d_idx),
        .o_num       (d_num),
        .o_busy      (d_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_live    <= '0;
            r_upd     <= '0;
            r_next    <= '0;
            r_md_sq   <= '0;
            r_lost    <= LOST_LIMIT_RST;
            r_p0_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
            r_rd_idx  <= '0;
            r_keep    <= '0;
            r_removed <= '0;
        end else begin
            // register writes, taken at any time
            if (i_cfg.valid) begin
                if (i_cfg.index == CFG_MAX_DISTANCE) begin
                    r_md_sq <= 32'(i_cfg.data) * 32'(i_cfg.data);
                end else if (i_cfg.index == CFG_LOST_LIMIT) begin
                    r_lost <= i_cfg.data[MISS_W-1:0];
                end
            end

            // read issued this cycle shows up as data next cycle
            r_p0_vld <= mem_rd_en;
            r_p0_idx <= mem_rd_addr;
            if (mem_rd_en) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end

            if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_box     <= {i_in.box_x[COORD_BITS-1:0], i_in.box_y[COORD_BITS-1:0],
                                      i_in.box_w[COORD_BITS-1:0], i_in.box_h[COORD_BITS-1:0]};
                        r_rd_idx  <= '0;
                        r_keep    <= '0;
                        r_removed <= '0;
                        r_found   <= 1'b0;
                        r_state   <= (i_in.kind == KIND_FRAME) ? S_FRAME : S_SCAN;
                    end
                end
                S_SCAN: begin
                    // first hit in table order wins, later ones drain unused
                    if (d_vld && d_hit && !r_found) begin
                        r_found   <= 1'b1;
                        r_hit_idx <= d_idx;
                        r_hit_num <= d_num;
                    end
                    if (scan_end) begin
                        r_res_kind <= KIND_BOX;
                        r_res_rem  <= '0;
                        if (r_found) begin
                            r_upd[r_hit_idx] <= 1'b1;
                            r_res_num  <= r_hit_num;
                            r_res_pos  <= r_hit_idx;
                            r_res_new  <= 1'b0;
                            r_res_drop <= 1'b0;
                            r_res_live <= r_live;
                        end else if (room) begin
                            r_upd[r_live[IDXW-1:0]] <= 1'b1;
                            r_next     <= r_next + 1'b1;
                            r_live     <= r_live + 1'b1;
                            r_res_num  <= r_next + 1'b1;
                            r_res_pos  <= r_live[IDXW-1:0];
                            r_res_new  <= 1'b1;
                            r_res_drop <= 1'b0;
                            r_res_live <= r_live + 1'b1;
                        end else begin
                            r_res_num  <= '0;
                            r_res_pos  <= '0;
                            r_res_new  <= 1'b0;
                            r_res_drop <= 1'b1;
                            r_res_live <= r_live;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_FRAME: begin
                    // survivors are written down to the compacted position
                    if (r_p0_vld) begin
                        if (gone) begin
                            r_removed <= r_removed + 1'b1;
                        end else begin
                            r_keep <= r_keep + 1'b1;
                        end
                    end
                    if (frame_end) begin
                        r_upd      <= '0;
                        r_live     <= r_keep;
                        r_res_kind <= KIND_FRAME;
                        r_res_num  <= '0;
                        r_res_pos  <= '0;
                        r_res_new  <= 1'b0;
                        r_res_drop <= 1'b0;
                        r_res_live <= r_keep;
                        r_res_rem  <= r_removed;
                        r_state    <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out_kind <= r_res_kind;
                        r_out_num  <= r_res_num;
                        r_out_pos  <= r_res_pos;
                        r_out_new  <= r_res_new;
                        r_out_drop <= r_res_drop;
                        r_out_live <= r_res_live;
                        r_out_rem  <= r_res_rem;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid          = r_out_vld;
    assign o_out.result_kind    = r_out_kind;
    assign o_out.track_number   = r_out_num;
    assign o_out.table_position = 5'(r_out_pos);
    assign o_out.is_new         = r_out_new;
    assign o_out.dropped        = r_out_drop;
    assign o_out.live_count     = 6'(r_out_live);
    assign o_out.removed_count  = 6'(r_out_rem);

    // table never holds more than its capacity
    `CTT_ASSERT_IMP(a_live_bound, i_clk, i_rst_n, 1'b1, r_live <= CNTW'(MAX_TRACKS))
    // a drop is only reported when the table is full
    `CTT_ASSERT_IMP(a_drop_full, i_clk, i_rst_n, r_out_vld && r_out_drop,
        r_out_live == CNTW'(MAX_TRACKS))
    // distance pipeline is drained whenever a new item can enter
    `CTT_ASSERT_IMP(a_idle_drained, i_clk, i_rst_n, r_state == S_IDLE, !d_busy && !r_p0_vld)
    // frame end leaves no updated marks behind
    `CTT_ASSERT_NXT(a_frame_clear, i_clk, i_rst_n, r_state == S_FRAME && frame_end,
        r_upd == '0)
endmodule

/* tb/ctt_tb_if.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ctt testbench channel helpers
// records used by the track table testbench to hold pending transactions
// ----------------------------------------------------------------------------
package ctt_tb_pkg;
    typedef struct packed {
        logic        kind;
        logic [11:0] box_x;
        logic [11:0] box_y;
        logic [11:0] box_w;
        logic [11:0] box_h;
    } detection_t;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] track_number;
        logic [4:0]  table_position;
        logic        is_new;
        logic        dropped;
        logic [5:0]  live_count;
        logic [5:0]  removed_count;
    } track_result_t;
endpackage

/* tb/tb_centroid_track_table.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_centroid_track_table
// drives detections and frame ends with random bursts and output stalls,
// predicts every result with a behavioral track table and compares fields
// ----------------------------------------------------------------------------
module tb_centroid_track_table;
    import ctt_pkg::*;
    import ctt_tb_pkg::*;

    localparam int TRACKS    = 32;
    localparam int CYCLE_CAP = 1500000;

    logic i_clk;
    logic i_rst_n;

    ctt_in_if  in_ch ();
    ctt_out_if out_ch ();
    ctt_cfg_if cfg_ch ();

    centroid_track_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // predictor state: a copy of the track table
    logic [15:0] dist_limit;
    logic [7:0]  miss_limit;
    logic [11:0] trk_box [TRACKS][4];
    logic [31:0] trk_num [TRACKS];
    logic        trk_upd [TRACKS];
    logic [7:0]  trk_miss [TRACKS];
    int          trk_live;
    logic [31:0] last_num;

    detection_t    pending_items[$];
    track_result_t expected_results[$];
    int            mismatch_count;
    longint        cycle_count;
    logic          in_fire;

    // squared centre distance compare, wide enough for no overflow
    function automatic logic centre_near(int e, detection_t d);
        longint ax, ay, bx, by, dx, dy, md;
        ax = trk_box[e][0] + (trk_box[e][2] >> 1);
        ay = trk_box[e][1] + (trk_box[e][3] >> 1);
        bx = d.box_x + (d.box_w >> 1);
        by = d.box_y + (d.box_h >> 1);
        dx = ax - bx;
        dy = ay - by;
        md = dist_limit;
        return dx * dx + dy * dy <= md * md;
    endfunction

    // advance the table by one transaction and return the expected result
    function automatic track_result_t track_update(detection_t d);
        track_result_t r;
        int keep, limit;
        logic found;
        r = '0;
        r.result_kind = d.kind;
        found = 1'b0;
        if (d.kind == KIND_BOX) begin
            for (int i = 0; i < trk_live && !found; i++) begin
                if (centre_near(i, d)) begin
                    trk_box[i] = '{d.box_x, d.box_y, d.box_w, d.box_h};
                    trk_upd[i] = 1'b1;
                    trk_miss[i] = '0;
                    r.track_number = trk_num[i];
                    r.table_position = 5'(i);
                    found = 1'b1;
                end
            end
            if (!found) begin
                if (trk_live < TRACKS) begin
                    last_num = last_num + 1;
                    trk_box[trk_live] = '{d.box_x, d.box_y, d.box_w, d.box_h};
                    trk_num[trk_live] = last_num;
                    trk_upd[trk_live] = 1'b1;
                    trk_miss[trk_live] = '0;
                    r.track_number = last_num;
                    r.table_position = 5'(trk_live);
                    r.is_new = 1'b1;
                    trk_live++;
                end else begin
                    r.dropped = 1'b1;
                end
            end
        end else begin
            // zero limit acts as one
            limit = (miss_limit == 0) ? 1 : miss_limit;
            keep = 0;
            for (int i = 0; i < trk_live; i++) begin
                if (!trk_upd[i] && trk_miss[i] != MISS_SAT)
                    trk_miss[i]++;
                if (trk_miss[i] >= limit) begin
                    r.removed_count++;
                end else begin
                    trk_box[keep] = trk_box[i];
                    trk_num[keep] = trk_num[i];
                    trk_miss[keep] = trk_miss[i];
                    trk_upd[keep] = 1'b0;
                    keep++;
                end
            end
            trk_live = keep;
        end
        r.live_count = 6'(trk_live);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // register write through the config channel, block idle
    task automatic write_register(logic [7:0] idx, logic [15:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx == CFG_MAX_DISTANCE) dist_limit = val;
        else if (idx == CFG_LOST_LIMIT) miss_limit = val[7:0];
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic detection_t box_item(int x, int y, int w, int h);
        detection_t d;
        d.kind = KIND_BOX;
        d.box_x = 12'(x);
        d.box_y = 12'(y);
        d.box_w = 12'(w);
        d.box_h = 12'(h);
        return d;
    endfunction

    function automatic detection_t frame_item();
        detection_t d;
        d = detection_t'($urandom);
        d.kind = KIND_FRAME;
        return d;
    endfunction

    // wait until the queue drained and every result came back
    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_results.size() != 0 || in_ch.valid)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // one video frame: a few objects drifting around centres, plus noise
    task automatic queue_frame(int n_obj, int spread);
        for (int k = 0; k < n_obj; k++) begin
            if ($urandom_range(0, 9) == 0)
                pending_items.push_back(detection_t'($urandom) & ~49'h1_0000_0000_0000);
            else
                pending_items.push_back(box_item(
                    k * 120 + $urandom_range(0, spread), 500 + $urandom_range(0, spread),
                    $urandom_range(0, 60), $urandom_range(0, 60)));
        end
        pending_items.push_back(frame_item());
    endtask

    // input transaction taken at the last rising edge
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && in_ch.valid && in_ch.ready;
    end

    // driver: bursts of random length separated by random gaps
    int burst_left;
    int gap_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            burst_left  <= 0;
            gap_left    <= 0;
        end else if (in_ch.valid && !in_fire) begin
            // hold the transaction until accepted
        end else if (gap_left > 0) begin
            in_ch.valid <= 1'b0;
            gap_left    <= gap_left - 1;
        end else if (pending_items.size() != 0) begin
            detection_t d;
            d = pending_items.pop_front();
            in_ch.valid <= 1'b1;
            {in_ch.kind, in_ch.box_x, in_ch.box_y, in_ch.box_w, in_ch.box_h} <= d;
            expected_results.push_back(track_update(d));
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 12);
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 60);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // receiver stall pattern: phases of always ready, random and long stall
    int stall_phase;
    always @(negedge i_clk) begin
        stall_phase <= (cycle_count % 700 < 200) ? 0 : (cycle_count % 700 < 550) ? 1 : 2;
        case (stall_phase)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= $urandom_range(0, 2) != 0;
            default: out_ch.ready <= $urandom_range(0, 15) == 0;
        endcase
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                track_result_t e;
                e = expected_results.pop_front();
                if (out_ch.result_kind !== e.result_kind)
                    report_mismatch("result_kind", out_ch.result_kind, e.result_kind);
                if (out_ch.track_number !== e.track_number)
                    report_mismatch("track_number", out_ch.track_number, e.track_number);
                if (out_ch.table_position !== e.table_position)
                    report_mismatch("table_position", out_ch.table_position,
                                    e.table_position);
                if (out_ch.is_new !== e.is_new)
                    report_mismatch("is_new", out_ch.is_new, e.is_new);
                if (out_ch.dropped !== e.dropped)
                    report_mismatch("dropped", out_ch.dropped, e.dropped);
                if (out_ch.live_count !== e.live_count)
                    report_mismatch("live_count", out_ch.live_count, e.live_count);
                if (out_ch.removed_count !== e.removed_count)
                    report_mismatch("removed_count", out_ch.removed_count, e.removed_count);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_CAP) begin
            $display("centroid_track_table regression: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        cycle_count = 0;
        mismatch_count = 0;
        in_ch.valid = 1'b0;
        in_ch.kind = 1'b0;
        in_ch.box_x = '0;
        in_ch.box_y = '0;
        in_ch.box_w = '0;
        in_ch.box_h = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        dist_limit = '0;
        miss_limit = LOST_LIMIT_RST;
        trk_live = 0;
        last_num = '0;
        for (int i = 0; i < TRACKS; i++) begin
            trk_upd[i] = 1'b0;
            trk_miss[i] = '0;
            trk_num[i] = '0;
            trk_box[i] = '{default: '0};
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset distance zero, exact centre matches only
        pending_items.push_back(box_item(0, 0, 0, 0));
        pending_items.push_back(box_item(0, 0, 1, 1));          // same centre via halving
        pending_items.push_back(box_item(4095, 4095, 4095, 4095));
        pending_items.push_back(box_item(4095, 4095, 4094, 4095)); // same centre via halving
        pending_items.push_back(box_item(4095, 4095, 4095, 4095)); // updated entry again
        pending_items.push_back(frame_item());
        pending_items.push_back(frame_item());
        wait_idle();

        // lost limit one: unmatched tracks vanish at the next frame end
        write_register(CFG_LOST_LIMIT, 16'd1);
        write_register(CFG_MAX_DISTANCE, 16'd0);
        pending_items.push_back(box_item(0, 0, 0, 0));
        pending_items.push_back(frame_item());
        pending_items.push_back(frame_item());
        wait_idle();

        // fill the table past full with distinct boxes, then drop
        for (int k = 0; k < TRACKS + 3; k++)
            pending_items.push_back(box_item(k * 100, 3000, 0, 0));
        pending_items.push_back(frame_item());
        pending_items.push_back(frame_item());
        wait_idle();

        // zero lost limit acts as one; widest distance matches anything
        write_register(CFG_LOST_LIMIT, 16'd0);
        write_register(CFG_MAX_DISTANCE, 16'hFFFF);
        pending_items.push_back(box_item(10, 10, 2, 2));
        pending_items.push_back(box_item(4095, 0, 4095, 4095));
        pending_items.push_back(frame_item());
        pending_items.push_back(frame_item());
        wait_idle();

        // random phases with varied settings, largest lost limit included
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin write_register(CFG_LOST_LIMIT, 16'd255);
                         write_register(CFG_MAX_DISTANCE, 16'd20); end
                1: begin write_register(CFG_LOST_LIMIT, 16'd3);
                         write_register(CFG_MAX_DISTANCE, 16'd8); end
                2: begin write_register(CFG_LOST_LIMIT, 16'd2);
                         write_register(CFG_MAX_DISTANCE, 16'd60); end
                3: begin write_register(CFG_LOST_LIMIT, 16'd255);
                         write_register(CFG_MAX_DISTANCE, 16'd1); end
                4: begin write_register(CFG_LOST_LIMIT, 16'd5);
                         write_register(CFG_MAX_DISTANCE, 16'($urandom)); end
                default: begin write_register(CFG_LOST_LIMIT, 16'($urandom_range(1, 255)));
                         write_register(CFG_MAX_DISTANCE, 16'($urandom_range(0, 100))); end
            endcase
            for (int f = 0; f < 21; f++)
                queue_frame($urandom_range(0, 8), (p == 3) ? 3000 : 15);
            wait_idle();
        end

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("centroid_track_table regression: pass");
        end else begin
            $display("centroid_track_table regression: fail");
        end
        $finish;
    end
endmodule
